FILE: rtl/ubsd_pkg.sv
`timescale 1ns / 1ps

package ubsd_pkg;

    localparam int UBSD_QUEUE_DEPTH = 2;
    localparam int CP_W             = 31;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_BAD_CONT = 2'd2
    } t_status;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic [2:0] lead_len;   // 0: cannot lead a sequence
        logic       is_cont;    // matches 10xxxxxx
    } t_cls;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic [2:0]      seq_bytes;
        t_status         status;
        logic [7:0]      offending_byte;
    } t_res;

endpackage

FILE: rtl/ubsd_fifo.sv
`timescale 1ns / 1ps

module ubsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: rtl/ubsd_front.sv
`timescale 1ns / 1ps

module ubsd_front
    import ubsd_pkg::*;
(
    input  logic [7:0] i_data_byte,
    output t_cls       o_cls
);

    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;
    localparam logic [5:0] LEAD5_TAG = 6'b111110;
    localparam logic [6:0] LEAD6_TAG = 7'b1111110;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (!b[7])                  len = 3'd1;
        else if (b[7:5] == LEAD2_TAG) len = 3'd2;
        else if (b[7:4] == LEAD3_TAG) len = 3'd3;
        else if (b[7:3] == LEAD4_TAG) len = 3'd4;
        else if (b[7:2] == LEAD5_TAG) len = 3'd5;
        else if (b[7:1] == LEAD6_TAG) len = 3'd6;
        return len;
    endfunction

    always_comb begin
        o_cls.data     = i_data_byte;
        o_cls.lead_len = lead_length(i_data_byte);
        o_cls.is_cont  = (i_data_byte[7:6] == CONT_TAG);
    end

endmodule

FILE: rtl/ubsd_back.sv
`timescale 1ns / 1ps

module ubsd_back
    import ubsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cls i_cls,
    input  logic i_cls_valid,
    output logic o_cls_pop,
    input  logic i_res_full,
    output logic o_res_push,
    output t_res o_res
);

    logic [CP_W-1:0] r_acc, n_acc;
    logic [2:0]      r_left, n_left;
    logic [2:0]      r_len, n_len;
    logic            consume;

    // payload bits a leading byte carries: the low (7 - len) bits
    function automatic logic [CP_W-1:0] lead_payload(input logic [7:0] b,
                                                     input logic [2:0] len);
        logic [CP_W-1:0] p;
        p = '0;
        case (len)
            3'd2:    p[4:0] = b[4:0];
            3'd3:    p[3:0] = b[3:0];
            3'd4:    p[2:0] = b[2:0];
            3'd5:    p[1:0] = b[1:0];
            3'd6:    p[0]   = b[0];
            default: p      = '0;
        endcase
        return p;
    endfunction

    assign consume   = i_cls_valid & ~i_res_full;
    assign o_cls_pop = consume;

    always_comb begin
        n_acc      = r_acc;
        n_left     = r_left;
        n_len      = r_len;
        o_res_push = 1'b0;
        o_res      = '{code_point: '0, seq_bytes: 3'd1, status: ST_OK,
                       offending_byte: 8'd0};
        if (consume) begin
            if (r_left == 3'd0) begin
                if (i_cls.lead_len == 3'd0) begin
                    o_res_push           = 1'b1;
                    o_res.status         = ST_BAD_LEAD;
                    o_res.offending_byte = i_cls.data;
                end else if (i_cls.lead_len == 3'd1) begin
                    o_res_push       = 1'b1;
                    o_res.code_point = {{(CP_W - 8){1'b0}}, i_cls.data};
                end else begin
                    n_acc  = lead_payload(i_cls.data, i_cls.lead_len);
                    n_len  = i_cls.lead_len;
                    n_left = i_cls.lead_len - 3'd1;
                end
            end else if (!i_cls.is_cont) begin
                // broken sequence: the byte is dropped, not reparsed as a lead
                o_res_push           = 1'b1;
                o_res.status         = ST_BAD_CONT;
                o_res.seq_bytes      = r_len;
                o_res.offending_byte = i_cls.data;
                n_acc                = '0;
                n_left               = 3'd0;
                n_len                = 3'd0;
            end else begin
                n_acc  = {r_acc[CP_W-7:0], i_cls.data[5:0]};
                n_left = r_left - 3'd1;
                if (r_left == 3'd1) begin
                    o_res_push       = 1'b1;
                    o_res.code_point = {r_acc[CP_W-7:0], i_cls.data[5:0]};
                    o_res.seq_bytes  = r_len;
                    n_acc            = '0;
                    n_len            = 3'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_left <= 3'd0;
            r_len  <= 3'd0;
        end else begin
            r_acc  <= n_acc;
            r_left <= n_left;
            r_len  <= n_len;
        end
    end

endmodule

FILE: rtl/utf8_byte_stream_decoder.sv
`timescale 1ns / 1ps
// Channel  | Dir | Handshake        | Payload
// ---------+-----+------------------+-------------------------------------------------
// byte in  | in  | push / full      | i_data_byte
// result   | out | empty / pop      | o_code_point, o_seq_bytes, o_status, o_offending_byte
//
// One byte per cycle while results drain; the back-end sequencer retires one byte a cycle.
// A byte crosses the byte queue, and its result shows once written into the result queue.
// Valid bytes that end no sequence (multi-byte leads, inner continuations) give no result.
// Reset is synchronous, active low, and empties both queues and the sequencer.
// Pop low stalls the back end when results fill; bytes enter until the byte queue fills.

module utf8_byte_stream_decoder
    import ubsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = UBSD_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  logic [7:0]      i_data_byte,
    output logic            empty,
    input  logic            pop,
    output logic [CP_W-1:0] o_code_point,
    output logic [2:0]      o_seq_bytes,
    output logic [1:0]      o_status,
    output logic [7:0]      o_offending_byte
);

    t_cls cls_in, cls_out;
    logic cls_empty, cls_pop;
    t_res res_in, res_out;
    logic res_push, res_full;

    ubsd_front u_front (
        .i_data_byte (i_data_byte),
        .o_cls       (cls_in)
    );

    ubsd_fifo #(
        .WIDTH ($bits(t_cls)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .o_full  (full),
        .i_pop   (cls_pop),
        .o_data  (cls_out),
        .o_empty (cls_empty)
    );

    ubsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls       (cls_out),
        .i_cls_valid (~cls_empty),
        .o_cls_pop   (cls_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    ubsd_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_code_point     = res_out.code_point;
    assign o_seq_bytes      = res_out.seq_bytes;
    assign o_status         = res_out.status;
    assign o_offending_byte = res_out.offending_byte;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_back_pops_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cls_pop |-> !cls_empty)
        else $error("back end consumed from an empty queue");

    a_ok_has_no_offender: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_OK) |-> o_offending_byte == 8'd0)
        else $error("ok result carries an offending byte");

    a_error_has_zero_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |-> o_code_point == '0)
        else $error("error result carries a code point");

    a_seq_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_seq_bytes != 3'd0 && o_seq_bytes != 3'd7))
        else $error("sequence length out of range");

endmodule
